/* src/page_frame_allocator_fifo_swap_defines.svh */
// Assertion macros shared by the page frame allocator RTL.
`ifndef PAGE_FRAME_ALLOCATOR_FIFO_SWAP_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_FIFO_SWAP_DEFINES_SVH
`ifndef SYNTH
`define PFA_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  prop) else $error("page frame allocator check failed");
`define PFA_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk_i) prop) else \
  $error("page frame allocator reset check failed");
`else
`define PFA_ASSERT(lbl, prop)
`define PFA_ASSERT_RST(lbl, prop)
`endif
`endif

/* src/pfa_pkg.sv */
// Types, codes and defaults of the page frame allocator.
`timescale 1ns / 1ps
package pfa_pkg;

  localparam int FRAMES_DEF      = 4096;
  localparam int QUEUE_DEPTH_DEF = 4096;
  localparam int SWAP_SLOTS_DEF  = 4096;
  localparam logic [12:0] FRAME_LIMIT_RST = 13'd4096;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_RECORD  = 2'd2;
  localparam logic [1:0] MODE_RELEASE = 2'd3;

  localparam logic [3:0] STS_FREE_LIST    = 4'd0;
  localparam logic [3:0] STS_BUMP         = 4'd1;
  localparam logic [3:0] STS_EVICTED      = 4'd2;
  localparam logic [3:0] STS_NO_VICTIM    = 4'd3;
  localparam logic [3:0] STS_NO_SLOT      = 4'd4;
  localparam logic [3:0] STS_RECORDED     = 4'd5;
  localparam logic [3:0] STS_QUEUE_FULL   = 4'd6;
  localparam logic [3:0] STS_FREED        = 4'd7;
  localparam logic [3:0] STS_ALREADY_FREE = 4'd8;
  localparam logic [3:0] STS_RELEASED     = 4'd9;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_POP, ST_FREE_RD, ST_FREE_CHK, ST_SKIP_RD, ST_SKIP_CHK,
    ST_SCAN_RD, ST_SCAN_CHK, ST_VIC_RD, ST_VIC_CHK, ST_REL_RD, ST_REL_CHK,
    ST_TRIM_RD, ST_TRIM_CHK, ST_QREL_RD, ST_QREL_CHK, ST_EMIT
  } state_e;

  typedef struct packed {
    logic [7:0]  owner;
    logic [11:0] frame;
    logic [26:0] vpn;
    logic [38:0] pte;
  } victim_t;

  typedef struct packed {
    logic       used;
    logic [7:0] owner;
  } slot_t;

endpackage

/* src/page_frame_allocator_fifo_swap.sv */
// Page frame allocator with a FIFO free list, bump pointer and FIFO eviction.
`timescale 1ns / 1ps
`include "page_frame_allocator_fifo_swap_defines.svh"
// Each accepted item yields exactly one result item. After reset the block
// runs a clearing pass over its free-list flags, queue live bits and
// swap-slot table, during which it stalls input items; configuration writes
// are taken at any time. All the tables are memories with one write port
// and one registered read port, walked by an index counter (the trim by
// the slot mark) under a small sequencer, so the cost of an item is set by
// how many table entries it must visit. An eviction skips the dead queue
// heads, scans the swap slots up to the lowest free one and then reads the
// victim. A release frees the owner's slots below the slot mark, trims the
// trailing free slots off the mark and then clears the owner's live entries
// in the whole queue. The next item is accepted as soon as the sequencer is
// back in idle, even while the previous result still waits in the output
// register. The single register frame_limit (offset 0) caps the bump
// pointer; a value above FRAMES acts as FRAMES and zero turns the bump tier
// off.
module page_frame_allocator_fifo_swap #(
  parameter int FRAMES      = pfa_pkg::FRAMES_DEF,
  parameter int QUEUE_DEPTH = pfa_pkg::QUEUE_DEPTH_DEF,
  parameter int SWAP_SLOTS  = pfa_pkg::SWAP_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [11:0] frame_index_i,
  input  logic [26:0] virtual_page_i,
  input  logic [38:0] entry_address_i,
  input  logic [7:0]  owner_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [11:0] granted_frame_o,
  output logic [11:0] swap_slot_o,
  output logic [26:0] victim_page_o,
  output logic [38:0] victim_entry_o
);

  localparam int FIW  = $clog2(FRAMES);
  localparam int FCW  = $clog2(FRAMES + 1);
  localparam int SUMW = FCW + 1;
  localparam int QIW  = $clog2(QUEUE_DEPTH);
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SIW  = $clog2(SWAP_SLOTS);
  localparam int SCW  = $clog2(SWAP_SLOTS + 1);
  localparam int MAXFQ = (FRAMES > QUEUE_DEPTH) ? FRAMES : QUEUE_DEPTH;
  localparam int MAXD  = (MAXFQ > SWAP_SLOTS) ? MAXFQ : SWAP_SLOTS;
  localparam int IXW   = $clog2(MAXD + 1);

  // Configuration register.
  logic [12:0] frame_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit_q <= pfa_pkg::FRAME_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
      frame_limit_q <= pwdata[12:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? 32'(frame_limit_q) : 32'd0;

  // Control state.
  pfa_pkg::state_e state_q, state_d;
  logic [FIW-1:0] free_head_q, free_head_d;
  logic [FCW-1:0] free_count_q, free_count_d;
  logic [FCW-1:0] bump_next_q, bump_next_d;
  logic [QIW-1:0] queue_head_q, queue_head_d;
  logic [QIW-1:0] queue_tail_q, queue_tail_d;
  logic [QCW-1:0] queue_count_q, queue_count_d;
  logic [SCW-1:0] mark_q, mark_d;
  logic [IXW-1:0] idx_q, idx_d;
  logic [SIW-1:0] slot_q, slot_d;
  logic           out_valid_q;

  // Latched operands of the item at work.
  logic [FIW-1:0] op_fidx_q;
  logic [7:0]     op_owner_q;

  // Memories and their ports.
  logic [FIW-1:0]   free_ring_q [FRAMES];
  logic             onfl_q      [FRAMES];
  logic             vlive_q     [QUEUE_DEPTH];
  pfa_pkg::victim_t vmem_q      [QUEUE_DEPTH];
  pfa_pkg::slot_t   smem_q      [SWAP_SLOTS];

  logic [FIW-1:0] ring_rd_q;
  logic           onfl_rd_q;
  logic           vlive_rd_q;
  pfa_pkg::victim_t vmem_rd_q;
  pfa_pkg::slot_t   smem_rd_q;

  logic             ring_we;
  logic [FIW-1:0]   ring_waddr, ring_wdata;
  logic             onfl_we, onfl_wdata;
  logic [FIW-1:0]   onfl_waddr;
  logic             vlive_we, vlive_wdata;
  logic [QIW-1:0]   vlive_waddr, vlive_raddr;
  logic             vmem_we;
  logic [QIW-1:0]   vmem_waddr, vmem_raddr;
  pfa_pkg::victim_t vmem_wdata;
  logic             smem_we;
  logic [SIW-1:0]   smem_waddr, smem_raddr;
  pfa_pkg::slot_t   smem_wdata;

  // Pending result.
  logic        res_load;
  logic [3:0]  res_status_d, res_status_q;
  logic [11:0] res_frame_d, res_frame_q;
  logic [11:0] res_slot_d, res_slot_q;
  logic [26:0] res_page_d, res_page_q;
  logic [38:0] res_entry_d, res_entry_q;

  logic in_acc, out_free, bump_ok, frame_ok;
  logic [SUMW-1:0] ring_sum;
  logic [FIW-1:0]  ring_tail;
  logic [FIW-1:0]  free_head_inc;
  logic [QIW-1:0]  queue_head_inc, queue_tail_inc;

  assign in_stall_o = (state_q != pfa_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // The effective limit is min(frame_limit, FRAMES).
  assign bump_ok  = (32'(bump_next_q) < 32'(frame_limit_q)) &&
                    (32'(bump_next_q) < 32'(FRAMES));
  assign frame_ok = 32'(frame_index_i) < 32'(FRAMES);

  // Tail of the free ring: head plus count, wrapped once.
  assign ring_sum  = SUMW'(free_head_q) + SUMW'(free_count_q);
  assign ring_tail = (ring_sum >= SUMW'(FRAMES)) ? FIW'(ring_sum - SUMW'(FRAMES))
                                                 : FIW'(ring_sum);
  assign free_head_inc  = (free_head_q == FIW'(FRAMES - 1)) ? '0 : free_head_q + 1'b1;
  assign queue_head_inc = (queue_head_q == QIW'(QUEUE_DEPTH - 1)) ? '0
                                                                   : queue_head_q + 1'b1;
  assign queue_tail_inc = (queue_tail_q == QIW'(QUEUE_DEPTH - 1)) ? '0
                                                                   : queue_tail_q + 1'b1;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfa_pkg::ST_CLEAR: begin
        if (idx_q == IXW'(MAXD - 1)) state_d = pfa_pkg::ST_IDLE;
      end
      pfa_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (mode_i)
            pfa_pkg::MODE_ALLOC: begin
              if (free_count_q != '0) state_d = pfa_pkg::ST_POP;
              else if (bump_ok)       state_d = pfa_pkg::ST_EMIT;
              else                    state_d = pfa_pkg::ST_SKIP_RD;
            end
            pfa_pkg::MODE_FREE:   state_d = frame_ok ? pfa_pkg::ST_FREE_RD : pfa_pkg::ST_EMIT;
            pfa_pkg::MODE_RECORD: state_d = pfa_pkg::ST_EMIT;
            default:              state_d = pfa_pkg::ST_REL_RD;
          endcase
        end
      end
      pfa_pkg::ST_POP:      state_d = pfa_pkg::ST_EMIT;
      pfa_pkg::ST_FREE_RD:  state_d = pfa_pkg::ST_FREE_CHK;
      pfa_pkg::ST_FREE_CHK: state_d = pfa_pkg::ST_EMIT;
      pfa_pkg::ST_SKIP_RD: begin
        state_d = (queue_count_q == '0) ? pfa_pkg::ST_EMIT : pfa_pkg::ST_SKIP_CHK;
      end
      pfa_pkg::ST_SKIP_CHK: begin
        state_d = vlive_rd_q ? pfa_pkg::ST_SCAN_RD : pfa_pkg::ST_SKIP_RD;
      end
      pfa_pkg::ST_SCAN_RD: begin
        state_d = (idx_q == IXW'(SWAP_SLOTS)) ? pfa_pkg::ST_EMIT : pfa_pkg::ST_SCAN_CHK;
      end
      pfa_pkg::ST_SCAN_CHK: begin
        state_d = smem_rd_q.used ? pfa_pkg::ST_SCAN_RD : pfa_pkg::ST_VIC_RD;
      end
      pfa_pkg::ST_VIC_RD:  state_d = pfa_pkg::ST_VIC_CHK;
      pfa_pkg::ST_VIC_CHK: state_d = pfa_pkg::ST_EMIT;
      pfa_pkg::ST_REL_RD: begin
        state_d = (idx_q >= IXW'(mark_q)) ? pfa_pkg::ST_TRIM_RD : pfa_pkg::ST_REL_CHK;
      end
      pfa_pkg::ST_REL_CHK: state_d = pfa_pkg::ST_REL_RD;
      pfa_pkg::ST_TRIM_RD: begin
        state_d = (mark_q == '0) ? pfa_pkg::ST_QREL_RD : pfa_pkg::ST_TRIM_CHK;
      end
      pfa_pkg::ST_TRIM_CHK: begin
        state_d = smem_rd_q.used ? pfa_pkg::ST_QREL_RD : pfa_pkg::ST_TRIM_RD;
      end
      pfa_pkg::ST_QREL_RD: begin
        state_d = (idx_q == IXW'(QUEUE_DEPTH)) ? pfa_pkg::ST_EMIT : pfa_pkg::ST_QREL_CHK;
      end
      pfa_pkg::ST_QREL_CHK: state_d = pfa_pkg::ST_QREL_RD;
      pfa_pkg::ST_EMIT: begin
        if (out_free) state_d = pfa_pkg::ST_IDLE;
      end
      default: state_d = pfa_pkg::ST_IDLE;
    endcase
  end

  // Datapath control, memory ports and counter updates.
  always_comb begin
    free_head_d   = free_head_q;
    free_count_d  = free_count_q;
    bump_next_d   = bump_next_q;
    queue_head_d  = queue_head_q;
    queue_tail_d  = queue_tail_q;
    queue_count_d = queue_count_q;
    mark_d        = mark_q;
    idx_d         = idx_q;
    slot_d        = slot_q;

    ring_we     = 1'b0;
    ring_waddr  = ring_tail;
    ring_wdata  = op_fidx_q;
    onfl_we     = 1'b0;
    onfl_waddr  = op_fidx_q;
    onfl_wdata  = 1'b0;
    vlive_we    = 1'b0;
    vlive_waddr = queue_head_q;
    vlive_wdata = 1'b0;
    vlive_raddr = queue_head_q;
    vmem_we     = 1'b0;
    vmem_waddr  = queue_tail_q;
    vmem_wdata  = '{owner: owner_id_i, frame: frame_index_i, vpn: virtual_page_i,
                    pte: entry_address_i};
    vmem_raddr  = queue_head_q;
    smem_we     = 1'b0;
    smem_waddr  = SIW'(idx_q);
    smem_wdata  = '0;
    smem_raddr  = SIW'(idx_q);

    res_load     = 1'b0;
    res_status_d = pfa_pkg::STS_RELEASED;
    res_frame_d  = '0;
    res_slot_d   = '0;
    res_page_d   = '0;
    res_entry_d  = '0;

    unique case (state_q)
      pfa_pkg::ST_CLEAR: begin
        onfl_we     = 32'(idx_q) < 32'(FRAMES);
        onfl_waddr  = FIW'(idx_q);
        vlive_we    = 32'(idx_q) < 32'(QUEUE_DEPTH);
        vlive_waddr = QIW'(idx_q);
        smem_we     = 32'(idx_q) < 32'(SWAP_SLOTS);
        idx_d       = idx_q + 1'b1;
      end
      pfa_pkg::ST_IDLE: begin
        if (in_acc) begin
          idx_d = '0;
          unique case (mode_i)
            pfa_pkg::MODE_ALLOC: begin
              if (free_count_q == '0 && bump_ok) begin
                res_load     = 1'b1;
                res_status_d = pfa_pkg::STS_BUMP;
                res_frame_d  = 12'(bump_next_q);
                bump_next_d  = bump_next_q + 1'b1;
              end
            end
            pfa_pkg::MODE_FREE: begin
              if (!frame_ok) begin
                res_load     = 1'b1;
                res_status_d = pfa_pkg::STS_ALREADY_FREE;
              end
            end
            pfa_pkg::MODE_RECORD: begin
              res_load = 1'b1;
              if (queue_count_q >= QCW'(QUEUE_DEPTH)) begin
                res_status_d = pfa_pkg::STS_QUEUE_FULL;
              end else begin
                vmem_we       = 1'b1;
                vlive_we      = 1'b1;
                vlive_waddr   = queue_tail_q;
                vlive_wdata   = 1'b1;
                queue_tail_d  = queue_tail_inc;
                queue_count_d = queue_count_q + 1'b1;
                res_status_d  = pfa_pkg::STS_RECORDED;
              end
            end
            default: ;
          endcase
        end
      end
      pfa_pkg::ST_POP: begin
        // The ring read at the head was issued when the item was taken.
        onfl_we      = 1'b1;
        onfl_waddr   = ring_rd_q;
        free_head_d  = free_head_inc;
        free_count_d = free_count_q - 1'b1;
        res_load     = 1'b1;
        res_status_d = pfa_pkg::STS_FREE_LIST;
        res_frame_d  = 12'(ring_rd_q);
      end
      pfa_pkg::ST_FREE_RD: ;
      pfa_pkg::ST_FREE_CHK: begin
        res_load = 1'b1;
        if (onfl_rd_q) begin
          res_status_d = pfa_pkg::STS_ALREADY_FREE;
        end else begin
          onfl_we      = 1'b1;
          onfl_wdata   = 1'b1;
          ring_we      = 1'b1;
          free_count_d = free_count_q + 1'b1;
          res_status_d = pfa_pkg::STS_FREED;
        end
      end
      pfa_pkg::ST_SKIP_RD: begin
        if (queue_count_q == '0) begin
          res_load     = 1'b1;
          res_status_d = pfa_pkg::STS_NO_VICTIM;
        end
      end
      pfa_pkg::ST_SKIP_CHK: begin
        // Dead heads are dropped for good, even if no slot turns up.
        if (!vlive_rd_q) begin
          queue_head_d  = queue_head_inc;
          queue_count_d = queue_count_q - 1'b1;
        end else begin
          idx_d = '0;
        end
      end
      pfa_pkg::ST_SCAN_RD: begin
        if (idx_q == IXW'(SWAP_SLOTS)) begin
          res_load     = 1'b1;
          res_status_d = pfa_pkg::STS_NO_SLOT;
        end
      end
      pfa_pkg::ST_SCAN_CHK: begin
        if (!smem_rd_q.used) slot_d = SIW'(idx_q);
        else                 idx_d  = idx_q + 1'b1;
      end
      pfa_pkg::ST_VIC_RD: ;
      pfa_pkg::ST_VIC_CHK: begin
        smem_we       = 1'b1;
        smem_waddr    = slot_q;
        smem_wdata    = '{used: 1'b1, owner: vmem_rd_q.owner};
        if (SCW'(slot_q) + SCW'(1) > mark_q) mark_d = SCW'(slot_q) + SCW'(1);
        vlive_we      = 1'b1;
        queue_head_d  = queue_head_inc;
        queue_count_d = queue_count_q - 1'b1;
        res_load      = 1'b1;
        res_status_d  = pfa_pkg::STS_EVICTED;
        res_frame_d   = vmem_rd_q.frame;
        res_slot_d    = 12'(slot_q);
        res_page_d    = vmem_rd_q.vpn;
        res_entry_d   = vmem_rd_q.pte;
      end
      pfa_pkg::ST_REL_RD: ;
      pfa_pkg::ST_REL_CHK: begin
        if (smem_rd_q.used && smem_rd_q.owner == op_owner_q) begin
          smem_we    = 1'b1;
          smem_wdata = '{used: 1'b0, owner: smem_rd_q.owner};
        end
        idx_d = idx_q + 1'b1;
      end
      pfa_pkg::ST_TRIM_RD: begin
        smem_raddr = SIW'(mark_q - SCW'(1));
        if (mark_q == '0) idx_d = '0;
      end
      pfa_pkg::ST_TRIM_CHK: begin
        if (!smem_rd_q.used) mark_d = mark_q - 1'b1;
        else                 idx_d  = '0;
      end
      pfa_pkg::ST_QREL_RD: begin
        vlive_raddr = QIW'(idx_q);
        vmem_raddr  = QIW'(idx_q);
        if (idx_q == IXW'(QUEUE_DEPTH)) begin
          res_load     = 1'b1;
          res_status_d = pfa_pkg::STS_RELEASED;
        end
      end
      pfa_pkg::ST_QREL_CHK: begin
        if (vlive_rd_q && vmem_rd_q.owner == op_owner_q) begin
          vlive_we    = 1'b1;
          vlive_waddr = QIW'(idx_q);
        end
        idx_d = idx_q + 1'b1;
      end
      pfa_pkg::ST_EMIT: ;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= pfa_pkg::ST_CLEAR;
      free_head_q   <= '0;
      free_count_q  <= '0;
      bump_next_q   <= '0;
      queue_head_q  <= '0;
      queue_tail_q  <= '0;
      queue_count_q <= '0;
      mark_q        <= '0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      free_head_q   <= free_head_d;
      free_count_q  <= free_count_d;
      bump_next_q   <= bump_next_d;
      queue_head_q  <= queue_head_d;
      queue_tail_q  <= queue_tail_d;
      queue_count_q <= queue_count_d;
      mark_q        <= mark_d;
      idx_q         <= idx_d;
      if (state_q == pfa_pkg::ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    if (in_acc) begin
      op_fidx_q  <= FIW'(frame_index_i);
      op_owner_q <= owner_id_i;
    end
    if (res_load) begin
      res_status_q <= res_status_d;
      res_frame_q  <= res_frame_d;
      res_slot_q   <= res_slot_d;
      res_page_q   <= res_page_d;
      res_entry_q  <= res_entry_d;
    end
    if (state_q == pfa_pkg::ST_EMIT && out_free) begin
      status_o        <= res_status_q;
      granted_frame_o <= res_frame_q;
      swap_slot_o     <= res_slot_q;
      victim_page_o   <= res_page_q;
      victim_entry_o  <= res_entry_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Memories, each with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (ring_we) free_ring_q[ring_waddr] <= ring_wdata;
    ring_rd_q <= free_ring_q[free_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (onfl_we) onfl_q[onfl_waddr] <= onfl_wdata;
    onfl_rd_q <= onfl_q[op_fidx_q];
  end

  always_ff @(posedge clk_i) begin
    if (vlive_we) vlive_q[vlive_waddr] <= vlive_wdata;
    vlive_rd_q <= vlive_q[vlive_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vmem_we) vmem_q[vmem_waddr] <= vmem_wdata;
    vmem_rd_q <= vmem_q[vmem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (smem_we) smem_q[smem_waddr] <= smem_wdata;
    smem_rd_q <= smem_q[smem_raddr];
  end

  // Checks.
  `PFA_ASSERT_RST(a_stall_in_reset, !rst_ni |-> in_stall_o)
  `PFA_ASSERT(a_free_count_bound, 32'(free_count_q) <= 32'(FRAMES))
  `PFA_ASSERT(a_queue_count_bound, 32'(queue_count_q) <= 32'(QUEUE_DEPTH))
  `PFA_ASSERT(a_mark_bound, 32'(mark_q) <= 32'(SWAP_SLOTS))
  `PFA_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o)
  `PFA_ASSERT(a_status_range, out_valid_o |-> status_o <= pfa_pkg::STS_RELEASED)

endmodule
